FILE: design/cls_pkg.sv
// Shared types and constants for the command-line argument splitter.
// No dependencies; imported by cls_core, cls_outq and the top level.
package cls_pkg;

  localparam int unsigned MaxResults = 3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic [15:0] CAP_RESET = 16'd36864;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ARGEND = 2'd1,
    KIND_EOL    = 2'd2,
    KIND_OVF    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] count;
  } result_t;

  // All results caused by one item; cnt is how many of res are in use.
  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [1:0]               cnt;
  } group_t;

  typedef struct packed {
    logic        in_quotes;
    logic        in_token;
    logic [15:0] pend;
    logic [15:0] used;
    logic        failed;
  } line_state_t;

endpackage

FILE: design/cls_core.sv
// Line state registers and per-item splitting logic.
// Depends on cls_pkg.
module cls_core import cls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  ch,
  input  logic [15:0] cap,
  output group_t      grp
);

  line_state_t st_r, st_nxt;

  function automatic logic fits(input logic [15:0] used, input logic [15:0] need,
                                input logic [15:0] cap_v);
    logic [16:0] total;
    total = {1'b0, used} + {1'b0, need};
    return total <= {1'b0, cap_v};
  endfunction

  always_comb begin
    logic [1:0]  n;
    logic        ovf;
    logic        fin;
    logic        clr;
    logic [15:0] half;
    n      = 2'd0;
    ovf    = 1'b0;
    fin    = 1'b0;
    clr    = 1'b0;
    half   = {1'b0, st_r.pend[15:1]};
    st_nxt = st_r;
    grp    = '0;

    if (st_r.failed) begin
      // discard until end of line
      if (ch == CH_NUL) begin
        grp.res[n] = '{KIND_EOL, 8'h00, 16'h0000};
        n = n + 2'd1;
        clr = 1'b1;
      end
    end else if (ch == CH_BSL) begin
      if (st_r.pend != 16'hFFFF) begin
        st_nxt.pend = st_r.pend + 16'd1;
      end
      st_nxt.in_token = 1'b1;
    end else begin
      if (st_r.pend != 16'h0000) begin
        st_nxt.pend = 16'h0000;
        if (ch == CH_QUOTE) begin
          fin = 1'b1;
          if (half != 16'h0000) begin
            if (fits(st_nxt.used, half, cap)) begin
              st_nxt.used = st_nxt.used + half;
              grp.res[n] = '{KIND_DATA, CH_BSL, half};
              n = n + 2'd1;
            end else begin
              ovf = 1'b1;
            end
          end
          if (!ovf) begin
            if (st_r.pend[0]) begin
              if (fits(st_nxt.used, 16'd1, cap)) begin
                st_nxt.used = st_nxt.used + 16'd1;
                grp.res[n] = '{KIND_DATA, CH_QUOTE, 16'd1};
                n = n + 2'd1;
              end else begin
                ovf = 1'b1;
              end
            end else begin
              st_nxt.in_quotes = !st_r.in_quotes;
            end
          end
        end else if (fits(st_nxt.used, st_r.pend, cap)) begin
          st_nxt.used = st_nxt.used + st_r.pend;
          grp.res[n] = '{KIND_DATA, CH_BSL, st_r.pend};
          n = n + 2'd1;
        end else begin
          ovf = 1'b1;
        end
      end

      if (!fin && !ovf) begin
        if (ch == CH_NUL) begin
          if (st_r.in_token) begin
            if (fits(st_nxt.used, 16'd1, cap)) begin
              st_nxt.used = st_nxt.used + 16'd1;
              grp.res[n] = '{KIND_ARGEND, 8'h00, 16'h0000};
              n = n + 2'd1;
            end else begin
              ovf = 1'b1;
            end
          end
          if (!ovf) begin
            grp.res[n] = '{KIND_EOL, 8'h00, 16'h0000};
            n = n + 2'd1;
            clr = 1'b1;
          end
        end else if ((ch == CH_SPACE || ch == CH_TAB) && !st_r.in_quotes) begin
          if (st_r.in_token) begin
            if (fits(st_nxt.used, 16'd1, cap)) begin
              st_nxt.used = st_nxt.used + 16'd1;
              grp.res[n] = '{KIND_ARGEND, 8'h00, 16'h0000};
              n = n + 2'd1;
              st_nxt.in_token = 1'b0;
            end else begin
              ovf = 1'b1;
            end
          end
        end else if (ch == CH_QUOTE) begin
          st_nxt.in_quotes = !st_r.in_quotes;
          st_nxt.in_token  = 1'b1;
        end else if (fits(st_nxt.used, 16'd1, cap)) begin
          st_nxt.used = st_nxt.used + 16'd1;
          grp.res[n] = '{KIND_DATA, ch, 16'd1};
          n = n + 2'd1;
          st_nxt.in_token = 1'b1;
        end else begin
          ovf = 1'b1;
        end
      end

      if (ovf) begin
        st_nxt.failed = 1'b1;
        grp.res[n] = '{KIND_OVF, 8'h00, 16'h0000};
        n = n + 2'd1;
        if (ch == CH_NUL) begin
          grp.res[n] = '{KIND_EOL, 8'h00, 16'h0000};
          n = n + 2'd1;
          clr = 1'b1;
        end
      end
    end

    if (clr) begin
      st_nxt = '0;
    end
    grp.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: design/cls_outq.sv
// Result group register: holds the results of one item and hands them out one per beat.
// Depends on cls_pkg.
module cls_outq import cls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  group_t      grp,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     res,
  output logic        res_last
);

  result_t [MaxResults-1:0] res_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign res       = res_r[idx_r];
  assign res_last  = (idx_r == cnt_r - 2'd1);
  assign pop       = out_valid && out_ready;
  // free when empty or when the last result of the group leaves this cycle
  assign can_load  = !out_valid || (pop && res_last);

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load && grp.cnt != 2'd0) begin
      cnt_nxt = grp.cnt;
      idx_nxt = 2'd0;
    end else if (pop) begin
      if (res_last) begin
        cnt_nxt = 2'd0;
        idx_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && grp.cnt != 2'd0) begin
      res_r <= grp.res;
    end
  end

endmodule

FILE: design/command_line_argument_splitter.sv
// Command-line argument splitter, top level.
// The first result of an item is valid the cycle after the item is accepted.
// Throughput (when out_ready is high): one item per cycle while each item gives at
// most one result; an item with k results occupies the result group register for k
// output beats. Reset (rst_n, synchronous): clears line state and empties the result
// register; capacity returns to 36864. Depends on cls_pkg, cls_core, cls_outq.
module command_line_argument_splitter import cls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] out_repeat_count,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] cap_r;
  logic        accept;
  group_t      grp;
  result_t     res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  assign accept = in_valid && in_ready;

  cls_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .ch     (in_ch),
    .cap    (cap_r),
    .grp    (grp)
  );

  cls_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .grp       (grp),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res),
    .res_last  (out_last)
  );

  assign out_kind         = res.kind;
  assign out_byte         = res.data_byte;
  assign out_repeat_count = res.count;

endmodule
